// ===== src/btb_pkg.sv =====
// ----------------------------------------------------------------------------
// BTB predictor package
// Shared types and constants for the branch target buffer predictor.
// ----------------------------------------------------------------------------
package btb_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 5;
    localparam int TAG_W       = 30;

    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HISTORY_LEN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAG_LEN      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNTER_INIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GLOBAL_HIST  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GLOBAL_TABLE = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SHARE_MODE   = 3'd6;

    localparam logic [1:0] SHARE_LSB = 2'd1;
    localparam logic [1:0] SHARE_MSB = 2'd2;

    localparam logic [0:0] ACT_PREDICT = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_REFILL,
        ST_WRITE,
        ST_RESULT
    } btb_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;   // clear one counter row/slot this cycle
        logic clear_start;  // restart the clearing sweep
        logic capture;      // take the input item
        logic lookup;       // register the reads
        logic refill_step;  // reset one counter of the allocated row
        logic write;        // write back the row and counter
        logic load_out;     // load the result register
    } btb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic refill_done;
        logic need_refill;
        logic is_update;
    } btb_status_t;

endpackage

// ===== src/btb_ctrl.sv =====
// ----------------------------------------------------------------------------
// BTB predictor controller
// Sequences clearing, lookup, row refill, write-back and result hand-off.
// ----------------------------------------------------------------------------
module btb_ctrl import btb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_hit,
    input  logic        s_accept,
    input  logic        m_accept,
    input  btb_status_t status,
    output btb_cmd_t    cmd,
    output logic        s_ready,
    output logic        m_valid
);

    btb_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (status.clear_done) state_next = ST_IDLE;
            ST_IDLE:   if (s_accept) state_next = ST_LOOKUP;
            ST_LOOKUP: begin
                if (status.is_update && status.need_refill) begin
                    state_next = ST_REFILL;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_REFILL: if (status.refill_done) state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_RESULT;
            ST_RESULT: if (m_accept) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd         = '0;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.clear_start = cfg_hit;
        unique case (state_reg)
            ST_CLEAR:  cmd.clear_step = 1'b1;
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_accept;
            end
            ST_LOOKUP: cmd.lookup = 1'b1;
            ST_REFILL: cmd.refill_step = 1'b1;
            ST_WRITE: begin
                cmd.write    = status.is_update;
                cmd.load_out = 1'b1;
            end
            ST_RESULT: m_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== src/btb_datapath.sv =====
// ----------------------------------------------------------------------------
// BTB predictor datapath
// Holds the BTB rows, the counter memories, histories and statistics.
// ----------------------------------------------------------------------------
module btb_datapath import btb_pkg::*; #(
    parameter int MAX_ROWS    = 32,
    parameter int MAX_HISTORY = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  btb_cmd_t              cmd,
    output btb_status_t           status,
    input  logic                  cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_action,
    input  logic [31:0]           in_pc,
    input  logic [31:0]           in_target,
    input  logic                  in_taken,
    input  logic [31:0]           in_prior,
    output logic                  out_ptaken,
    output logic [31:0]           out_ptarget,
    output logic                  out_flush,
    output logic [31:0]           out_branches,
    output logic [31:0]           out_flushes
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SLOTS = 1 << MAX_HISTORY;
    localparam int CW    = RW + MAX_HISTORY;
    localparam int KMAX  = $clog2(MAX_ROWS);
    localparam int HLW   = $clog2(MAX_HISTORY + 1);

    // Configuration.
    logic [2:0] index_bits_reg;
    logic [3:0] history_len_reg;
    logic [4:0] tag_len_reg;
    logic [1:0] counter_init_reg;
    logic       global_history_reg, global_table_reg;
    logic [1:0] share_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_bits_reg     <= 3'd0;
            history_len_reg    <= 4'd1;
            tag_len_reg        <= 5'd0;
            counter_init_reg   <= 2'd1;
            global_history_reg <= 1'b0;
            global_table_reg   <= 1'b0;
            share_mode_reg     <= 2'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_INDEX_BITS:   index_bits_reg     <= cfg_data[2:0];
                REG_HISTORY_LEN:  history_len_reg    <= cfg_data[3:0];
                REG_TAG_LEN:      tag_len_reg        <= cfg_data;
                REG_COUNTER_INIT: counter_init_reg   <= cfg_data[1:0];
                REG_GLOBAL_HIST:  global_history_reg <= cfg_data[0];
                REG_GLOBAL_TABLE: global_table_reg   <= cfg_data[0];
                REG_SHARE_MODE:   share_mode_reg     <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes.
    logic [2:0]          eff_k;
    logic [HLW-1:0]      eff_h;
    logic [4:0]          eff_t;
    logic [MAX_HISTORY-1:0] hmask;
    logic [RW-1:0]       rmask;

    always_comb begin
        eff_k = (32'(index_bits_reg) > KMAX) ? 3'(KMAX) : index_bits_reg;
        eff_h = (32'(history_len_reg) > MAX_HISTORY) ? HLW'(MAX_HISTORY)
                                                      : HLW'(history_len_reg);
        eff_t = (tag_len_reg > 5'd30) ? 5'd30 : tag_len_reg;
        hmask = MAX_HISTORY'((33'd1 << eff_h) - 33'd1);
        rmask = RW'((33'd1 << eff_k) - 33'd1);
    end

    // Captured item.
    logic        act_reg, taken_reg;
    logic [31:0] pc_reg, target_reg, prior_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg    <= in_action;
            pc_reg     <= in_pc;
            target_reg <= in_target;
            taken_reg  <= in_taken;
            prior_reg  <= in_prior;
        end
    end

    logic [RW-1:0]    row;
    logic [TAG_W-1:0] tag;
    logic [31:0]      pc_plus4, next_addr;
    always_comb begin
        row       = RW'(pc_reg[31:2]) & rmask;
        tag       = TAG_W'((pc_reg >> (eff_k + 3'd2)) & ((33'd1 << eff_t) - 33'd1));
        pc_plus4  = pc_reg + 32'd4;
        next_addr = taken_reg ? target_reg : pc_plus4;
    end

    // Row fields: few rows, valid bits cleared at once.
    logic [MAX_ROWS-1:0]    valid_reg;
    logic [TAG_W-1:0]       tag_mem      [MAX_ROWS];
    logic [31:0]            target_mem   [MAX_ROWS];
    logic [MAX_HISTORY-1:0] rhist_mem    [MAX_ROWS];
    logic [MAX_HISTORY-1:0] shist_reg;

    // A row that misses counts as having zero history, which is also the history
    // that an update allocating it starts from.
    logic                   hit;
    logic [MAX_HISTORY-1:0] hist_cur;
    logic [MAX_HISTORY-1:0] sidx;
    logic [CW-1:0]          caddr;
    always_comb begin
        hit      = valid_reg[row] && (tag_mem[row] == tag);
        hist_cur = (global_history_reg ? shist_reg
                    : (hit ? rhist_mem[row] : '0)) & hmask;
        if (global_table_reg && share_mode_reg == SHARE_LSB) begin
            sidx = (MAX_HISTORY'(pc_reg >> 2) ^ hist_cur) & hmask;
        end else if (global_table_reg && share_mode_reg == SHARE_MSB) begin
            sidx = (MAX_HISTORY'(pc_reg >> 16) ^ hist_cur) & hmask;
        end else begin
            sidx = hist_cur;
        end
        caddr = {row, hist_cur};
    end

    // Counter memories, one read per item and one write-back per update item.
    logic [1:0] rcnt_mem [MAX_ROWS*SLOTS];
    logic [1:0] scnt_mem [SLOTS];
    logic [1:0] rcnt_q, scnt_q;

    // Clearing sweep over the counter memories.
    logic [CW:0]          clr_reg;
    logic [MAX_HISTORY:0] refill_reg;
    logic                 hit_q;

    assign status.clear_done  = (clr_reg == (CW+1)'(MAX_ROWS*SLOTS - 1));
    assign status.refill_done = (refill_reg == (MAX_HISTORY+1)'(SLOTS - 1));
    assign status.need_refill = !hit && !global_table_reg;
    assign status.is_update   = act_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clear_start || !aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_step && !status.clear_done) begin
            clr_reg <= clr_reg + 1'b1;
        end
        if (cmd.lookup) begin
            refill_reg <= '0;
        end else if (cmd.refill_step) begin
            refill_reg <= refill_reg + 1'b1;
        end
    end

    logic [1:0] cnt_old, cnt_new;
    always_comb begin
        cnt_old = global_table_reg ? scnt_q : (hit_q ? rcnt_q : counter_init_reg);
        if (taken_reg) begin
            cnt_new = (cnt_old == 2'd3) ? cnt_old : cnt_old + 2'd1;
        end else begin
            cnt_new = (cnt_old == 2'd0) ? cnt_old : cnt_old - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            rcnt_mem[clr_reg[CW-1:0]] <= counter_init_reg;
            if (clr_reg < (CW+1)'(SLOTS)) begin
                scnt_mem[clr_reg[MAX_HISTORY-1:0]] <= counter_init_reg;
            end
        end else if (cmd.refill_step) begin
            rcnt_mem[{row, refill_reg[MAX_HISTORY-1:0]}] <= counter_init_reg;
        end else if (cmd.write) begin
            if (global_table_reg) begin
                scnt_mem[hit_q ? sidx : sidx] <= cnt_new;
            end else begin
                rcnt_mem[caddr] <= cnt_new;
            end
        end
        if (cmd.lookup) begin
            rcnt_q <= rcnt_mem[caddr];
            scnt_q <= scnt_mem[sidx];
            hit_q  <= hit;
        end
    end

    logic [MAX_HISTORY-1:0] hist_base;
    assign hist_base = (global_history_reg || hit_q) ? hist_cur : '0;

    // Row state and histories.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_start) begin
            valid_reg <= '0;
            shist_reg <= '0;
        end else if (cmd.write) begin
            valid_reg[row] <= 1'b1;
            if (global_history_reg) begin
                shist_reg <= ((shist_reg << 1) | MAX_HISTORY'(taken_reg)) & hmask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            if (!hit_q) begin
                tag_mem[row]    <= tag;
                target_mem[row] <= target_reg;
            end
            if (!global_history_reg) begin
                rhist_mem[row] <= ((hist_base << 1) | MAX_HISTORY'(taken_reg)) & hmask;
            end else if (!hit_q) begin
                rhist_mem[row] <= '0;
            end
        end
    end

    // Statistics and result register.
    logic [31:0] upd_reg, fls_reg;
    logic        flush_now;
    assign flush_now = (prior_reg != next_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_start) begin
            upd_reg <= '0;
            fls_reg <= '0;
        end else if (cmd.write) begin
            if (upd_reg != '1) upd_reg <= upd_reg + 32'd1;
            if (flush_now && fls_reg != '1) fls_reg <= fls_reg + 32'd1;
        end
    end

    logic [1:0] pcnt;
    assign pcnt = global_table_reg ? scnt_q : rcnt_q;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (!act_reg) begin
                out_ptaken   <= hit_q && pcnt[1];
                out_ptarget  <= (hit_q && pcnt[1]) ? target_mem[row] : pc_plus4;
                out_flush    <= 1'b0;
                out_branches <= upd_reg;
                out_flushes  <= fls_reg;
            end else begin
                out_ptaken   <= 1'b0;
                out_ptarget  <= '0;
                out_flush    <= flush_now;
                out_branches <= (upd_reg != '1) ? upd_reg + 32'd1 : upd_reg;
                out_flushes  <= (flush_now && fls_reg != '1) ? fls_reg + 32'd1 : fls_reg;
            end
        end
    end

endmodule

// ===== src/btb_two_level_branch_predictor.sv =====
// Each item passes through the lookup, write and result states in order; an update
// that misses with per-row counters also passes through a refill of the row's counters.
// Items are handled one at a time: a new item is taken only after the last
// result has been accepted.
// Reset (and any write to a listed configuration register) starts a clearing
// pass through the counter memory, during which no item is taken.
// ----------------------------------------------------------------------------
// Two-level branch predictor with branch target buffer
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor import btb_pkg::*; #(
    parameter int MAX_ROWS    = 32,
    parameter int MAX_HISTORY = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input items.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata: pc[31:0], actual_target[63:32], taken[64], prior_prediction[96:65]
    input  logic [103:0]           s_tdata,
    // tuser: action[0]
    input  logic                   s_tuser,
    // Result items.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata: predict_taken[0], predicted_target[32:1], flush[33],
    // branch_count[65:34], flush_count[97:66]
    output logic [103:0]           m_tdata
);

    btb_cmd_t    cmd;
    btb_status_t status;
    logic        o_taken, o_flush;
    logic [31:0] o_target, o_br, o_fl;
    logic        cfg_hit;

    // Only writes to listed registers reinitialise the state.
    assign cfg_hit = cfg_we && (cfg_index <= REG_SHARE_MODE);

    btb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_hit  (cfg_hit),
        .s_accept (s_tvalid && s_tready),
        .m_accept (m_tvalid && m_tready),
        .status   (status),
        .cmd      (cmd),
        .s_ready  (s_tready),
        .m_valid  (m_tvalid)
    );

    btb_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_HISTORY (MAX_HISTORY)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_action    (s_tuser),
        .in_pc        (s_tdata[31:0]),
        .in_target    (s_tdata[63:32]),
        .in_taken     (s_tdata[64]),
        .in_prior     (s_tdata[96:65]),
        .out_ptaken   (o_taken),
        .out_ptarget  (o_target),
        .out_flush    (o_flush),
        .out_branches (o_br),
        .out_flushes  (o_fl)
    );

    assign m_tdata = {6'd0, o_fl, o_br, o_flush, o_target, o_taken};

endmodule

// ===== src/btb_checker.sv =====
// ----------------------------------------------------------------------------
// BTB predictor port checker
// Watches the top-level ports over time.
// ----------------------------------------------------------------------------
module btb_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // A result waiting to be taken holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: no input taken while a result is pending.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready with result pending");

    // A predict-taken result never reports a flush.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[33]))
        else $error("taken and flush together");

    // An accepted item cannot produce a result in the next cycle.
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result too early");

endmodule

bind btb_two_level_branch_predictor btb_checker u_btb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/btb_two_level_branch_predictor_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BTB predictor checker
// Watches the configuration port and both streams, keeps its own copy of the
// buffer and counter state, predicts each result and compares field by field.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor_checker import btb_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [103:0]           s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [103:0]           m_tdata,
    output int                     fail_count,
    output int                     pending
);

    localparam int ROWS  = 32;
    localparam int SLOTS = 256;

    typedef struct packed {
        logic        taken;
        logic [31:0] target;
        logic        flush;
        logic [31:0] branches;
        logic [31:0] flushes;
    } outcome_t;

    logic [2:0]  idx_bits_q;
    logic [3:0]  hist_len_q;
    logic [4:0]  tag_len_q;
    logic [1:0]  ctr_init_q;
    logic        glob_hist_q, glob_tab_q;
    logic [1:0]  share_q;

    logic        valid_a  [ROWS];
    logic [29:0] tag_a    [ROWS];
    logic [31:0] target_a [ROWS];
    logic [7:0]  hist_a   [ROWS];
    logic [7:0]  shared_hist;
    logic [1:0]  row_ctr  [ROWS*SLOTS];
    logic [1:0]  glob_ctr [SLOTS];
    logic [31:0] branch_total, flush_total;

    outcome_t expected_q[$];

    assign pending = expected_q.size();

    task automatic wipe_state();
        for (int i = 0; i < ROWS; i++) begin
            valid_a[i] = 0; tag_a[i] = 0; target_a[i] = 0; hist_a[i] = 0;
        end
        for (int i = 0; i < ROWS*SLOTS; i++) row_ctr[i] = ctr_init_q;
        for (int i = 0; i < SLOTS; i++) glob_ctr[i] = ctr_init_q;
        shared_hist = 0; branch_total = 0; flush_total = 0;
    endtask

    function automatic logic [7:0] hmask();
        int h;
        h = (hist_len_q > 8) ? 8 : hist_len_q;
        return 8'((1 << h) - 1);
    endfunction

    // Index of the selected counter: bit 16 set means the shared table.
    function automatic int counter_slot(logic [31:0] pc, int row);
        logic [7:0] h, pcb;
        h = (glob_hist_q ? shared_hist : hist_a[row]) & hmask();
        if (!glob_tab_q) return row*SLOTS + h;
        pcb = 0;
        if (share_q == SHARE_LSB) pcb = 8'(pc >> 2) & hmask();
        else if (share_q == SHARE_MSB) pcb = 8'(pc >> 16) & hmask();
        return 32'h10000 | ((pcb ^ h) & hmask());
    endfunction

    task automatic predict_branch(input logic upd, input logic [103:0] d);
        logic [31:0] pc, tgt, prior, nxt;
        logic        tk;
        int          k, row, slot, tl;
        logic [29:0] tg;
        logic [1:0]  c;
        outcome_t    o;
        pc = d[31:0]; tgt = d[63:32]; tk = d[64]; prior = d[96:65];
        k = (idx_bits_q > 5) ? 5 : idx_bits_q;
        row = (pc >> 2) & ((1 << k) - 1);
        tl = (tag_len_q > 30) ? 30 : tag_len_q;
        tg = 30'((64'(pc) >> (2 + k)) & ((64'd1 << tl) - 1));
        o = '0;
        if (!upd) begin
            slot = counter_slot(pc, row);
            c = slot[16] ? glob_ctr[slot[7:0]] : row_ctr[slot];
            if (valid_a[row] && tag_a[row] == tg && c > 1) begin
                o.taken = 1; o.target = target_a[row];
            end else o.target = pc + 4;
        end else begin
            nxt = tk ? tgt : pc + 4;
            if (branch_total != '1) branch_total++;
            if (prior != nxt) begin
                o.flush = 1;
                if (flush_total != '1) flush_total++;
            end
            if (!valid_a[row] || tag_a[row] != tg) begin
                valid_a[row] = 1;
                if (!glob_hist_q) hist_a[row] = 0;
                if (!glob_tab_q)
                    for (int i = 0; i < SLOTS; i++) row_ctr[row*SLOTS+i] = ctr_init_q;
                target_a[row] = tgt; tag_a[row] = tg;
            end
            slot = counter_slot(pc, row);
            c = slot[16] ? glob_ctr[slot[7:0]] : row_ctr[slot];
            if (tk && c < 3) c++;
            else if (!tk && c > 0) c--;
            if (slot[16]) glob_ctr[slot[7:0]] = c; else row_ctr[slot] = c;
            if (glob_hist_q) shared_hist = {shared_hist[6:0], tk} & hmask();
            else hist_a[row] = {hist_a[row][6:0], tk} & hmask();
        end
        o.branches = branch_total; o.flushes = flush_total;
        expected_q = {expected_q, o};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        outcome_t e;
        if (!aresetn) begin
            idx_bits_q = 0; hist_len_q = 1; tag_len_q = 0; ctr_init_q = 1;
            glob_hist_q = 0; glob_tab_q = 0; share_q = 0;
            wipe_state();
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_INDEX_BITS:   idx_bits_q  = cfg_data[2:0];
                    REG_HISTORY_LEN:  hist_len_q  = cfg_data[3:0];
                    REG_TAG_LEN:      tag_len_q   = cfg_data[4:0];
                    REG_COUNTER_INIT: ctr_init_q  = cfg_data[1:0];
                    REG_GLOBAL_HIST:  glob_hist_q = cfg_data[0];
                    REG_GLOBAL_TABLE: glob_tab_q  = cfg_data[0];
                    REG_SHARE_MODE:   share_q     = cfg_data[1:0];
                    default: ;
                endcase
                if (cfg_index <= REG_SHARE_MODE) wipe_state();
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $display("result item with no expectation waiting");
                    fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    if (m_tdata[0] !== e.taken)
                        report_mismatch("predict_taken", 32'(m_tdata[0]), 32'(e.taken));
                    if (m_tdata[32:1] !== e.target)
                        report_mismatch("predicted_target", m_tdata[32:1], e.target);
                    if (m_tdata[33] !== e.flush)
                        report_mismatch("flush", 32'(m_tdata[33]), 32'(e.flush));
                    if (m_tdata[65:34] !== e.branches)
                        report_mismatch("branch_count", m_tdata[65:34], e.branches);
                    if (m_tdata[97:66] !== e.flushes)
                        report_mismatch("flush_count", m_tdata[97:66], e.flushes);
                end
            end
            if (s_tvalid && s_tready)
                predict_branch(s_tuser != ACT_PREDICT, s_tdata);
        end
    end

endmodule

// ===== tb/btb_two_level_branch_predictor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BTB predictor testbench
// Drives predict and update items through several configurations and idling
// phases; the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor_tb;
    import btb_pkg::*;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid, s_tready;
    logic [103:0]           s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [103:0]           m_tdata;
    int                     fail_count, pending;

    // Idling percentages for each side, and the long hold-off on the result side.
    int   send_idle_pct, recv_stall_pct;
    int   hold_cycles = 0;
    logic hold_go     = 1'b0;
    logic hold_used   = 1'b0;
    // The branch addresses used in the current phase: a small set so that rows
    // hit and the counters train, with one pc differing from another only in the tag.
    logic [31:0] pc_pool[8];
    logic [31:0] tgt_pool[8];

    btb_two_level_branch_predictor u_top (.*);

    btb_two_level_branch_predictor_checker u_chk (.*);

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    // The receiver stalls at random, or holds off completely while a long
    // stretch is counted down, so that the block fills and stalls its input.
    always @(posedge aclk) begin
        if (hold_go && !hold_used) begin
            hold_used   <= 1'b1;
            hold_cycles <= 400;
            m_tready    <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one item and waits until it is accepted. The sender may idle first.
    task automatic send_item(input logic act, input logic [31:0] pc,
                             input logic [31:0] tgt, input logic tk,
                             input logic [31:0] prior);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, prior, tk, tgt, pc};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Waits until every expected result has come, then lets the block idle.
    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    // A configuration write restarts the clearing sweep; the block holds off
    // the following items until the sweep has finished.
    task automatic configure(input int ib, input int hl, input int tl, input int ci,
                             input int gh, input int gt, input int sm);
        write_reg(REG_INDEX_BITS, CFG_DATA_W'(ib));
        write_reg(REG_HISTORY_LEN, CFG_DATA_W'(hl));
        write_reg(REG_TAG_LEN, CFG_DATA_W'(tl));
        write_reg(REG_COUNTER_INIT, CFG_DATA_W'(ci));
        write_reg(REG_GLOBAL_HIST, CFG_DATA_W'(gh));
        write_reg(REG_GLOBAL_TABLE, CFG_DATA_W'(gt));
        write_reg(REG_SHARE_MODE, CFG_DATA_W'(sm));
        cfg_we <= 1'b0;
        for (int i = 0; i < 8; i++) begin
            pc_pool[i]  = $urandom;
            tgt_pool[i] = $urandom;
        end
        pc_pool[1] = pc_pool[0] ^ (32'h1 << $urandom_range(31, 7));
    endtask

    // Mostly well-formed traffic: each item is a predict or an update of a known
    // branch, picked at random; one in ten uses a fully random pc and target.
    task automatic random_items(input int count);
        logic [31:0] pc, tgt, prior;
        logic        tk;
        int          j;
        for (int n = 0; n < count; n++) begin
            j   = $urandom_range(7);
            pc  = pc_pool[j];
            tk  = $urandom_range(3) != 0;
            tgt = tgt_pool[j];
            if ($urandom_range(9) == 0) begin
                pc = $urandom; tgt = $urandom;
            end
            case ($urandom_range(2))
                0: prior = tk ? tgt : pc + 4;
                1: prior = tk ? pc + 4 : tgt;
                default: prior = $urandom;
            endcase
            if ($urandom_range(1)) send_item(ACT_PREDICT, pc, $urandom, 1'($urandom), $urandom);
            else send_item(~ACT_PREDICT, pc, tgt, tk, prior);
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tuser        = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part on the reset configuration and then on the extremes.
        send_item(ACT_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0);
        send_item(~ACT_PREDICT, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_item(ACT_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
        send_item(~ACT_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b1, 32'h0);
        send_item(ACT_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
        send_item(~ACT_PREDICT, 32'h0, 32'h1234_5678, 1'b0, 32'h4);
        send_item(~ACT_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h3);
        drain();
        // Oversized index, history, tag, and share code three.
        configure(7, 15, 31, 3, 0, 1, 3);
        send_item(~ACT_PREDICT, 32'hAAAA_AAA8, 32'h5555_5555, 1'b1, 32'h5555_5555);
        send_item(ACT_PREDICT, 32'hAAAA_AAA8, 32'h0, 1'b0, 32'h0);
        send_item(~ACT_PREDICT, 32'h5555_5554, 32'hAAAA_AAAA, 1'b0, 32'hAAAA_AAAA);
        send_item(ACT_PREDICT, 32'h5555_5554, 32'h0, 1'b0, 32'h0);
        drain();
        // Zero history length, strongly not taken, global history.
        configure(5, 0, 30, 0, 1, 0, 0);
        send_item(~ACT_PREDICT, 32'h0000_0010, 32'h100, 1'b1, 32'h100);
        send_item(~ACT_PREDICT, 32'h0000_0010, 32'h100, 1'b1, 32'h14);
        send_item(ACT_PREDICT, 32'h0000_0010, 32'h0, 1'b0, 32'h0);
        // Same row, different tag: reallocation.
        send_item(~ACT_PREDICT, 32'h8000_0010, 32'h200, 1'b1, 32'h200);
        send_item(ACT_PREDICT, 32'h0000_0010, 32'h0, 1'b0, 32'h0);
        drain();
        // A write beyond the register list must be ignored.
        write_reg(3'd7, 5'h1F);
        cfg_we <= 1'b0;
        drain();

        // Random phases across settings and idling patterns.
        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            case (p)
                0:  configure(0, 1, 0, 1, 0, 0, 0);
                1:  configure(5, 8, 30, 3, 1, 1, SHARE_LSB);
                2:  configure(3, 4, 10, 2, 1, 1, SHARE_MSB);
                3:  configure(2, 2, 3, 0, 0, 1, SHARE_LSB);
                default: configure($urandom_range(7), $urandom_range(15), $urandom_range(31),
                                   $urandom_range(3), $urandom_range(1), $urandom_range(1),
                                   $urandom_range(3));
            endcase
            if (p == 4) hold_go = 1'b1;
            random_items(90);
            drain();
        end

        if (fail_count == 0) begin
            $display("btb_two_level_branch_predictor test passed");
        end else begin
            $display("btb_two_level_branch_predictor test failed");
        end
        $finish;
    end

    initial begin
        #80ms;
        $display("btb_two_level_branch_predictor test failed");
        $finish;
    end

endmodule
